FILE: sv/tsr_pkg.sv
// Package: shared types and constants for the triangle sample rasterizer.
package tsr_pkg;

    localparam int unsigned MaxSamplesDefault = 64;
    localparam int unsigned MaxDimDefault     = 4096;
    localparam int unsigned FracBitsDefault   = 4;

    localparam logic [12:0] WidthReset  = 13'd640;
    localparam logic [12:0] HeightReset = 13'd480;

    localparam logic FuncVertex = 1'b0;
    localparam logic FuncSample = 1'b1;

    localparam logic KindBox   = 1'b0;
    localparam logic KindPixel = 1'b1;

    localparam logic CfgWidth  = 1'b0;
    localparam logic CfgHeight = 1'b1;

    localparam int unsigned CmdQueueDepth = 2;

    // one classified command from the front part to the back part
    typedef struct packed {
        logic        func;
        logic [1:0]  slot;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [47:0] color;
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  ox;
        logic [7:0]  oy;
        logic        last;
    } t_cmd;

    // one result beat
    typedef struct packed {
        logic        kind;
        logic [11:0] col;
        logic [11:0] row;
        logic        we;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [12:0] col_first;
        logic [12:0] col_end;
        logic [12:0] row_first;
        logic [12:0] row_end;
    } t_res;

endpackage

FILE: sv/tsr_front.sv
// Front part: accepts input beats, drops ignored items and queues commands.
module tsr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  tsr_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    output tsr_pkg::t_cmd  o_cmd,
    input  logic           i_take
);
    import tsr_pkg::*;

    localparam int unsigned PtrW = $clog2(CmdQueueDepth);

    t_cmd              r_mem [CmdQueueDepth];
    logic [PtrW-1:0]   r_wp, r_rp;
    logic [PtrW:0]     r_cnt;
    logic              do_push, do_pop, keep;

    // slot 3 vertex loads do nothing and never enter the queue
    assign keep    = (i_cmd.func == FuncSample) || (i_cmd.slot != 2'd3);
    assign o_full  = (r_cnt == (PtrW+1)'(CmdQueueDepth));
    assign do_push = i_push && !o_full && keep;
    assign o_valid = (r_cnt != '0);
    assign do_pop  = i_take && o_valid;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
        end
    end
endmodule

FILE: sv/tsr_div.sv
// Iterative unsigned divider, one quotient bit per cycle.
module tsr_div #(
    parameter int unsigned NW = 48,
    parameter int unsigned DW = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quo
);
    localparam int unsigned CntW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_d;
    logic [CntW-1:0] r_cnt;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial  = {r_rem[DW-1:0], r_q[NW-1]};
    assign diff   = trial - {1'b0, r_d};
    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q;

    // restoring division step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CntW'(NW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_d   <= i_den;
        end else if (o_busy) begin
            if (!diff[DW]) begin
                r_rem <= diff;
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end
endmodule

FILE: sv/tsr_back.sv
// Back part: sequencer that runs setup, sample tests, color interpolation and averaging.
module tsr_back #(
    parameter int unsigned MAX_SAMPLES = tsr_pkg::MaxSamplesDefault,
    parameter int unsigned MAX_DIM     = tsr_pkg::MaxDimDefault,
    parameter int unsigned FRAC_BITS   = tsr_pkg::FracBitsDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tsr_pkg::t_cmd  i_cmd,
    output logic           o_take,
    input  logic [12:0]    i_width,
    input  logic [12:0]    i_height,
    output logic           o_res_valid,
    output tsr_pkg::t_res  o_res,
    input  logic           i_res_take
);
    import tsr_pkg::*;

    localparam int unsigned HitW = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned Up   = 8 - FRAC_BITS;
    localparam int unsigned NumW = 60;
    localparam int unsigned DenW = 44;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MUL   = 10'b0000000010,
        ST_DEN   = 10'b0000000100,
        ST_TEST  = 10'b0000001000,
        ST_CMUL  = 10'b0000010000,
        ST_CSUM  = 10'b0000100000,
        ST_CDIV  = 10'b0001000000,
        ST_AVG   = 10'b0010000000,
        ST_ADIV  = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } t_state;

    t_state r_st;
    t_cmd   r_cmd;
    logic signed [15:0] r_cx [3];
    logic signed [15:0] r_cy [3];
    logic [47:0]        r_cc [3];
    logic signed [33:0] r_den;
    logic [21:0]        r_sum [3];
    logic [HitW-1:0]    r_hits;
    logic signed [40:0] r_p0, r_p1, r_nb, r_ng, r_d;
    logic [1:0]         r_k;
    logic [1:0]         r_step;
    logic signed [NumW:0] r_acc;
    t_res   r_res;
    t_res   r_out;
    logic   r_res_valid;
    logic   out_load;

    // clamped dimensions
    logic [12:0] w, h;
    assign w = (i_width == '0) ? 13'd1 :
               (i_width > 13'(MAX_DIM)) ? 13'(MAX_DIM) : i_width;
    assign h = (i_height == '0) ? 13'd1 :
               (i_height > 13'(MAX_DIM)) ? 13'(MAX_DIM) : i_height;

    // edge vectors, 17 bits signed
    logic signed [16:0] v1x, v1y, v2x, v2y;
    assign v1x = 17'(r_cx[1]) - 17'(r_cx[0]);
    assign v1y = 17'(r_cy[1]) - 17'(r_cy[0]);
    assign v2x = 17'(r_cx[2]) - 17'(r_cx[0]);
    assign v2y = 17'(r_cy[2]) - 17'(r_cy[0]);

    // sample vector at 8 fraction bits
    logic signed [24:0] v3x, v3y;
    assign v3x = 25'($signed({1'b0, r_cmd.col, r_cmd.ox}))
               - (25'(r_cx[0]) <<< Up);
    assign v3y = 25'($signed({1'b0, r_cmd.row, r_cmd.oy}))
               - (25'(r_cy[0]) <<< Up);

    // one shared signed multiplier pair, operands selected by step
    logic signed [24:0] ma, mb, mc, md;
    logic signed [41:0] pa, pb;
    always_comb begin
        ma = 25'(v1x); mb = 25'(v2y); mc = 25'(v1y); md = 25'(v2x);
        if (r_st == ST_MUL && r_cmd.func == FuncSample) begin
            if (r_step == 2'd0) begin
                ma = v3x; mb = 25'(v2y); mc = v3y; md = 25'(v2x);
            end else begin
                ma = 25'(v1x); mb = v3y; mc = 25'(v1y); md = v3x;
            end
        end
        pa = 42'(ma) * 42'(mb);
        pb = 42'(mc) * 42'(md);
    end

    // hit test on normalized sign
    logic signed [40:0] nbn, ngn, dn;
    logic               hit;
    assign nbn = r_d[40] ? -r_nb : r_nb;
    assign ngn = r_d[40] ? -r_ng : r_ng;
    assign dn  = r_d[40] ? -r_d  : r_d;
    assign hit = (r_den != '0) && (nbn > 0) && (ngn > 0) && ((nbn + ngn) < dn)
               && (r_hits < HitW'(MAX_SAMPLES));

    // color weight multiply: one channel term per cycle
    logic [15:0]        ch;
    logic signed [40:0] wt;
    logic signed [58:0] cprod;
    always_comb begin
        ch = r_cc[r_step][16*r_k +: 16];
        case (r_step)
            2'd0:    wt = dn - nbn - ngn;
            2'd1:    wt = nbn;
            default: wt = ngn;
        endcase
        cprod = 59'(wt) * $signed({43'd0, ch});
    end

    // divider shared by interpolation and averaging
    logic            div_start, div_busy;
    logic [NumW-1:0] div_num, div_quo;
    logic [DenW-1:0] div_den;
    tsr_div #(.NW(NumW), .DW(DenW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_busy(div_busy), .o_quo(div_quo)
    );

    logic [21:0] avg_sum;
    assign avg_sum = r_sum[r_k];
    always_comb begin
        div_start = 1'b0;
        div_num   = NumW'(r_acc);
        div_den   = DenW'(dn);
        if (r_st == ST_CSUM) begin
            div_start = 1'b1;
        end else if (r_st == ST_AVG) begin
            div_start = 1'b1;
            div_num   = NumW'(avg_sum) + NumW'(r_hits >> 1);
            div_den   = DenW'(r_hits);
        end
    end

    // box edges
    logic signed [15:0] mnx, mxx, mny, mxy;
    always_comb begin
        mnx = r_cx[0]; mxx = r_cx[0]; mny = r_cy[0]; mxy = r_cy[0];
        for (int i = 1; i < 3; i++) begin
            if (r_cx[i] < mnx) mnx = r_cx[i];
            if (r_cx[i] > mxx) mxx = r_cx[i];
            if (r_cy[i] < mny) mny = r_cy[i];
            if (r_cy[i] > mxy) mxy = r_cy[i];
        end
    end

    function automatic logic [12:0] box_edge(input logic signed [15:0] v,
                                             input logic up_dir,
                                             input logic [12:0] lim);
        logic signed [17:0] s;
        logic signed [17:0] f;
        s = up_dir ? (18'(v) + 18'(1 << FRAC_BITS)) : (18'(v) - 18'(1 << FRAC_BITS));
        f = s >>> FRAC_BITS;
        if (f < 0) return '0;
        if (f > $signed({5'd0, lim})) return lim;
        return f[12:0];
    endfunction

    logic [15:0] sat;
    assign sat = (div_quo > NumW'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];

    // the output register takes the staged beat once it is free
    assign out_load    = (r_st == ST_OUT) && (!r_res_valid || i_res_take);
    assign o_take      = (r_st == ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_res_valid <= 1'b0;
            r_den       <= '0;
            r_hits      <= '0;
            for (int i = 0; i < 3; i++) begin
                r_cx[i] <= '0; r_cy[i] <= '0; r_cc[i] <= '0; r_sum[i] <= '0;
            end
        end else begin
            // output beat register
            if (out_load) begin
                r_out       <= r_res;
                r_res_valid <= 1'b1;
            end else if (r_res_valid && i_res_take) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_cmd  <= i_cmd;
                        r_step <= '0;
                        if (i_cmd.func == FuncVertex) begin
                            r_cx[i_cmd.slot] <= $signed(i_cmd.vx);
                            r_cy[i_cmd.slot] <= $signed(i_cmd.vy);
                            r_cc[i_cmd.slot] <= i_cmd.color;
                            if (i_cmd.slot != 2'd2) r_den <= '0;
                            else r_st <= ST_MUL;
                        end else begin
                            r_st <= (r_den != '0) ? ST_MUL : ST_AVG;
                            r_k  <= '0;
                        end
                    end
                end
                ST_MUL: begin
                    if (r_cmd.func == FuncVertex) begin
                        r_p0 <= 41'(pa); r_p1 <= 41'(pb);
                        r_st <= ST_DEN;
                    end else if (r_step == 2'd0) begin
                        r_nb   <= 41'(pa - pb);
                        r_step <= 2'd1;
                    end else begin
                        r_ng   <= 41'(pa - pb);
                        r_d    <= 41'(r_den) <<< Up;
                        r_step <= '0;
                        r_st   <= ST_TEST;
                    end
                end
                ST_DEN: begin
                    r_den <= 34'(r_p0 - r_p1);
                    r_res.kind      <= KindBox;
                    r_res.col       <= '0; r_res.row <= '0; r_res.we <= 1'b0;
                    r_res.red       <= '0; r_res.green <= '0; r_res.blue <= '0;
                    r_res.col_first <= box_edge(mnx, 1'b0, w);
                    r_res.col_end   <= box_edge(mxx, 1'b1, w);
                    r_res.row_first <= box_edge(mny, 1'b0, h);
                    r_res.row_end   <= box_edge(mxy, 1'b1, h);
                    r_st <= ST_OUT;
                end
                ST_TEST: begin
                    r_k <= '0; r_step <= '0; r_acc <= '0;
                    if (hit) begin
                        r_st   <= ST_CMUL;
                        r_hits <= r_hits + 1'b1;
                    end else begin
                        r_st <= ST_AVG;
                    end
                end
                ST_CMUL: begin
                    // accumulate one weighted corner color term
                    r_acc <= r_acc + (NumW+1)'(cprod);
                    if (r_step == 2'd2) r_st <= ST_CSUM;
                    else r_step <= r_step + 1'b1;
                end
                ST_CSUM: begin
                    r_st <= ST_CDIV;
                end
                ST_CDIV: begin
                    if (!div_busy) begin
                        r_sum[r_k] <= r_sum[r_k] + div_quo[21:0];
                        r_acc  <= '0;
                        r_step <= '0;
                        if (r_k == 2'd2) begin
                            r_k  <= '0;
                            r_st <= ST_AVG;
                        end else begin
                            r_k  <= r_k + 1'b1;
                            r_st <= ST_CMUL;
                        end
                    end
                end
                ST_AVG: begin
                    if (!r_cmd.last) begin
                        r_st <= ST_IDLE;
                    end else begin
                        // pixel fields are set up on the first channel pass only
                        if (r_k == 2'd0) begin
                            r_res.kind      <= KindPixel;
                            r_res.col       <= r_cmd.col;
                            r_res.row       <= 12'(h - 13'd1 - {1'b0, r_cmd.row});
                            r_res.we        <= (r_hits != '0)
                                               && ({1'b0, r_cmd.col} < w)
                                               && ({1'b0, r_cmd.row} < h);
                            r_res.red       <= '0; r_res.green <= '0; r_res.blue <= '0;
                            r_res.col_first <= '0; r_res.col_end <= '0;
                            r_res.row_first <= '0; r_res.row_end <= '0;
                        end
                        r_st <= (r_hits != '0) ? ST_ADIV : ST_OUT;
                    end
                end
                ST_ADIV: begin
                    if (!div_busy) begin
                        case (r_k)
                            2'd0:    r_res.red   <= sat;
                            2'd1:    r_res.green <= sat;
                            default: r_res.blue  <= sat;
                        endcase
                        if (r_k == 2'd2) begin
                            r_st <= ST_OUT;
                        end else begin
                            r_k  <= r_k + 1'b1;
                            r_st <= ST_AVG;
                        end
                    end
                end
                ST_OUT: begin
                    // wait here while the previous beat still sits in the output
                    if (out_load) begin
                        if (r_cmd.func == FuncSample) begin
                            r_hits <= '0;
                            for (int i = 0; i < 3; i++) r_sum[i] <= '0;
                        end
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/triangle_sample_rasterizer_unit.sv
// Top level: triangle sample rasterizer with queue-style ports.
// A vertex load for slot 2 also runs setup and the bounding box. A hit
// adds three 60-step bit-serial divisions for the interpolated color, and the
// last sample of a pixel with hits adds three more for the average. Both sets
// of divisions run on the shared restoring divider. A two-entry command
// queue separates input acceptance from the sequencer, and one output
// register holds a beat until it is popped; the sequencer keeps working behind
// it and only waits in its output step while that register is still full.
module triangle_sample_rasterizer_unit #(
    parameter int unsigned MAX_SAMPLES = tsr_pkg::MaxSamplesDefault,
    parameter int unsigned MAX_DIM     = tsr_pkg::MaxDimDefault,
    parameter int unsigned FRAC_BITS   = tsr_pkg::FracBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [1:0]  i_vertex_slot,
    input  logic signed [15:0] i_vertex_x,
    input  logic signed [15:0] i_vertex_y,
    input  logic [15:0] i_vertex_red,
    input  logic [15:0] i_vertex_green,
    input  logic [15:0] i_vertex_blue,
    input  logic [11:0] i_pixel_col,
    input  logic [11:0] i_pixel_row,
    input  logic [7:0]  i_offset_x,
    input  logic [7:0]  i_offset_y,
    input  logic        i_last_sample,
    output logic        empty,
    input  logic        pop,
    output logic        o_result_kind,
    output logic [11:0] o_out_col,
    output logic [11:0] o_out_row,
    output logic        o_write_enable,
    output logic [15:0] o_out_red,
    output logic [15:0] o_out_green,
    output logic [15:0] o_out_blue,
    output logic [12:0] o_box_col_first,
    output logic [12:0] o_box_col_end,
    output logic [12:0] o_box_row_first,
    output logic [12:0] o_box_row_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import tsr_pkg::*;

    t_cmd        in_cmd, q_cmd;
    t_res        res;
    logic        q_valid, q_take, res_valid;
    logic [12:0] r_width, r_height;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WidthReset;
            r_height <= HeightReset;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CfgWidth) r_width  <= i_cfg_data;
            else                         r_height <= i_cfg_data;
        end
    end

    assign in_cmd = '{func: i_func, slot: i_vertex_slot, vx: i_vertex_x,
                      vy: i_vertex_y,
                      color: {i_vertex_blue, i_vertex_green, i_vertex_red},
                      col: i_pixel_col, row: i_pixel_row, ox: i_offset_x,
                      oy: i_offset_y, last: i_last_sample};

    tsr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_cmd(in_cmd), .o_valid(q_valid), .o_cmd(q_cmd), .i_take(q_take)
    );

    tsr_back #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS))
    u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(q_cmd),
        .o_take(q_take), .i_width(r_width), .i_height(r_height),
        .o_res_valid(res_valid), .o_res(res), .i_res_take(pop)
    );

    assign empty           = !res_valid;
    assign o_result_kind   = res.kind;
    assign o_out_col       = res.col;
    assign o_out_row       = res.row;
    assign o_write_enable  = res.we;
    assign o_out_red       = res.red;
    assign o_out_green     = res.green;
    assign o_out_blue      = res.blue;
    assign o_box_col_first = res.col_first;
    assign o_box_col_end   = res.col_end;
    assign o_box_row_first = res.row_first;
    assign o_box_row_end   = res.row_end;
endmodule

FILE: sim/tb.sv
// Self-checking testbench for the triangle sample rasterizer unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsr_pkg::*;

    localparam int IdleLimit = 20000;

    // one input beat as driven on the ports
    typedef struct {
        logic        func;
        logic [1:0]  slot;
        logic [15:0] vx, vy, r, g, b;
        logic [11:0] col, row;
        logic [7:0]  ox, oy;
        logic        last;
    } t_item;

    // directed stimulus row; chk_direct means the expected beat is typed in
    typedef struct {
        t_item item;
        bit    chk_direct;
        t_res  res;
    } t_row;

    logic i_clk = 0, i_rst_n = 0;
    logic push = 0, pop = 0;
    logic i_func = 0, i_last_sample = 0;
    logic [1:0] i_vertex_slot = 0;
    logic signed [15:0] i_vertex_x = 0, i_vertex_y = 0;
    logic [15:0] i_vertex_red = 0, i_vertex_green = 0, i_vertex_blue = 0;
    logic [11:0] i_pixel_col = 0, i_pixel_row = 0;
    logic [7:0] i_offset_x = 0, i_offset_y = 0;
    logic i_cfg_valid = 0, i_cfg_index = 0;
    logic [12:0] i_cfg_data = 0;
    logic full, empty, o_cfg_ready;
    logic o_result_kind, o_write_enable;
    logic [11:0] o_out_col, o_out_row;
    logic [15:0] o_out_red, o_out_green, o_out_blue;
    logic [12:0] o_box_col_first, o_box_col_end, o_box_row_first, o_box_row_end;

    triangle_sample_rasterizer_unit dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // predictor state
    longint px[3], py[3];
    longint pcol[3][3];
    longint pden;
    longint acc[3];
    int     nhits;
    int     wreg = 640, hreg = 480;

    t_res expected_q[$];
    int   errors = 0;
    int   idle_cycles = 0;
    bit   stall_free = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint dim_clamp(input int v);
        return v < 1 ? 1 : (v > 4096 ? 4096 : v);
    endfunction

    function automatic longint floor16(input longint v);
        return v >= 0 ? v / 16 : -((-v + 15) / 16);
    endfunction

    function automatic longint clip(input longint v, input longint hi);
        return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    // advance the predictor by one beat; returns 1 when a result follows
    function automatic bit raster_predict(input t_item it, output t_res res);
        longint w, h, mnx, mxx, mny, mxy;
        longint v1x, v1y, v2x, v2y, v3x, v3y, nb, ng, d, w0, num, avg;
        int s;
        w = dim_clamp(wreg);
        h = dim_clamp(hreg);
        res = '0;
        if (it.func == FuncVertex) begin
            if (it.slot == 2'd3) return 0;
            s = it.slot;
            px[s] = longint'($signed(it.vx));
            py[s] = longint'($signed(it.vy));
            pcol[s][0] = it.r; pcol[s][1] = it.g; pcol[s][2] = it.b;
            if (s != 2) begin
                pden = 0;
                return 0;
            end
            pden = (px[1]-px[0])*(py[2]-py[0]) - (py[1]-py[0])*(px[2]-px[0]);
            mnx = px[0]; mxx = px[0]; mny = py[0]; mxy = py[0];
            for (int i = 1; i < 3; i++) begin
                if (px[i] < mnx) mnx = px[i];
                if (px[i] > mxx) mxx = px[i];
                if (py[i] < mny) mny = py[i];
                if (py[i] > mxy) mxy = py[i];
            end
            res.kind = KindBox;
            res.col_first = 13'(clip(floor16(mnx - 16), w));
            res.col_end   = 13'(clip(floor16(mxx + 16), w));
            res.row_first = 13'(clip(floor16(mny - 16), h));
            res.row_end   = 13'(clip(floor16(mxy + 16), h));
            return 1;
        end
        if (pden != 0) begin
            v1x = px[1]-px[0]; v1y = py[1]-py[0];
            v2x = px[2]-px[0]; v2y = py[2]-py[0];
            v3x = longint'(it.col)*256 + it.ox - px[0]*16;
            v3y = longint'(it.row)*256 + it.oy - py[0]*16;
            nb = v3x*v2y - v3y*v2x;
            ng = v1x*v3y - v1y*v3x;
            d = pden * 16;
            if (d < 0) begin
                d = -d; nb = -nb; ng = -ng;
            end
            if (nb > 0 && ng > 0 && nb + ng < d && nhits < 64) begin
                w0 = d - nb - ng;
                for (int k = 0; k < 3; k++) begin
                    num = w0*pcol[0][k] + nb*pcol[1][k] + ng*pcol[2][k];
                    acc[k] += num / d;
                end
                nhits++;
            end
        end
        if (!it.last) return 0;
        res.kind = KindPixel;
        res.col = it.col;
        res.row = 12'(h - 1 - it.row);
        if (nhits > 0) begin
            res.we = (it.col < w && it.row < h);
            for (int k = 0; k < 3; k++) begin
                avg = (acc[k] + nhits/2) / nhits;
                if (avg > 65535) avg = 65535;
                if (k == 0) res.red = 16'(avg);
                else if (k == 1) res.green = 16'(avg);
                else res.blue = 16'(avg);
            end
        end
        acc = '{0, 0, 0};
        nhits = 0;
        return 1;
    endfunction

    // result side: pop at random (always when stall_free) and compare
    always @(negedge i_clk) begin
        if (i_rst_n) pop <= stall_free ? 1'b1 : ($urandom_range(99) >= 24);
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && pop && !empty) begin
            if (expected_q.size() == 0) begin
                $display("MISMATCH unexpected result beat");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_result_kind !== e.kind) report("kind", o_result_kind, e.kind);
                if (o_out_col !== e.col) report("col", o_out_col, e.col);
                if (o_out_row !== e.row) report("row", o_out_row, e.row);
                if (o_write_enable !== e.we) report("we", o_write_enable, e.we);
                if (o_out_red !== e.red) report("red", o_out_red, e.red);
                if (o_out_green !== e.green) report("green", o_out_green, e.green);
                if (o_out_blue !== e.blue) report("blue", o_out_blue, e.blue);
                if (o_box_col_first !== e.col_first)
                    report("col_first", o_box_col_first, e.col_first);
                if (o_box_col_end !== e.col_end) report("col_end", o_box_col_end, e.col_end);
                if (o_box_row_first !== e.row_first)
                    report("row_first", o_box_row_first, e.row_first);
                if (o_box_row_end !== e.row_end) report("row_end", o_box_row_end, e.row_end);
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send(input t_item it);
        t_res r;
        while (!stall_free && $urandom_range(99) < 24) begin
            push <= 0;
            @(negedge i_clk);
        end
        push <= 1;
        i_func <= it.func; i_vertex_slot <= it.slot;
        i_vertex_x <= it.vx; i_vertex_y <= it.vy;
        i_vertex_red <= it.r; i_vertex_green <= it.g; i_vertex_blue <= it.b;
        i_pixel_col <= it.col; i_pixel_row <= it.row;
        i_offset_x <= it.ox; i_offset_y <= it.oy; i_last_sample <= it.last;
        do @(posedge i_clk); while (full);
        if (raster_predict(it, r)) expected_q.insert(expected_q.size(), r);
        @(negedge i_clk);
    endtask

    task automatic drain();
        push <= 0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (800) @(negedge i_clk);
    endtask

    // valid stays high across back-to-back writes; the caller drops it
    task automatic cfg_write(input logic idx, input int val);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= 13'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CfgWidth) wreg = val & 13'h1fff; else hreg = val & 13'h1fff;
        @(negedge i_clk);
    endtask

    function automatic t_item vert(input int s, input int x, input int y,
                                   input int r, input int g, input int b);
        t_item it = '{default: 0};
        it.func = FuncVertex; it.slot = 2'(s); it.vx = 16'(x); it.vy = 16'(y);
        it.r = 16'(r); it.g = 16'(g); it.b = 16'(b);
        return it;
    endfunction

    function automatic t_item samp(input int c, input int rw, input int ox,
                                   input int oy, input bit l);
        t_item it = '{default: 0};
        it.func = FuncSample; it.col = 12'(c); it.row = 12'(rw);
        it.ox = 8'(ox); it.oy = 8'(oy);
        it.last = l;
        return it;
    endfunction

    function automatic t_item rnd_item();
        t_item it;
        it.func = 1'($urandom); it.slot = 2'($urandom);
        it.vx = 16'($urandom); it.vy = 16'($urandom);
        it.r = 16'($urandom); it.g = 16'($urandom); it.b = 16'($urandom);
        it.col = 12'($urandom); it.row = 12'($urandom);
        it.ox = 8'($urandom); it.oy = 8'($urandom);
        it.last = 1'($urandom);
        return it;
    endfunction

    t_row dir_tbl[$];

    task automatic add_row(input t_item it, input bit chk, input t_res r);
        t_row rw;
        rw.item = it; rw.chk_direct = chk; rw.res = r;
        dir_tbl.insert(dir_tbl.size(), rw);
    endtask

    initial begin
        t_res r0, rb;
        t_item it;
        int cx, cy, sz, nsamp;
        acc = '{0, 0, 0};
        nhits = 0; pden = 0;
        for (int i = 0; i < 3; i++) begin
            px[i] = 0; py[i] = 0; pcol[i] = '{0, 0, 0};
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed rows
        r0 = '0;
        rb = '0; rb.kind = KindPixel; rb.row = 12'd479;
        add_row(samp(0, 0, 128, 128, 1), 1, rb);                // no triangle yet
        add_row(vert(3, 100, 100, 1, 2, 3), 0, r0);             // slot 3 ignored
        add_row(vert(0, 16*10, 16*10, 65535, 0, 0), 0, r0);
        add_row(vert(1, 16*40, 16*10, 0, 65535, 0), 0, r0);
        rb = '0; rb.kind = KindBox; rb.col_first = 13'd9; rb.col_end = 13'd41;
        rb.row_first = 13'd9; rb.row_end = 13'd41;
        add_row(vert(2, 16*10, 16*40, 0, 0, 65535), 1, rb);
        add_row(samp(15, 15, 0, 0, 0), 0, r0);
        add_row(samp(15, 15, 128, 128, 0), 0, r0);
        add_row(samp(15, 15, 255, 255, 1), 0, r0);
        add_row(samp(38, 38, 128, 128, 1), 0, r0);              // miss
        add_row(samp(20, 20, 128, 128, 1), 0, r0);
        add_row(vert(0, -32768, -32768, 0, 0, 0), 0, r0);
        add_row(samp(20, 20, 128, 128, 1), 0, r0);              // cleared setup
        add_row(vert(1, 32767, -32768, 65535, 65535, 65535), 0, r0);
        rb = '0; rb.kind = KindBox; rb.col_end = 13'd640; rb.row_end = 13'd480;
        add_row(vert(2, -32768, 32767, 65535, 65535, 65535), 1, rb);
        add_row(samp(4095, 4095, 255, 255, 1), 0, r0);          // outside image
        add_row(samp(100, 100, 0, 255, 1), 0, r0);
        add_row(vert(0, 0, 0, 5, 5, 5), 0, r0);
        add_row(vert(1, 0, 0, 5, 5, 5), 0, r0);
        rb = '0; rb.kind = KindBox; rb.col_end = 13'd1; rb.row_end = 13'd1;
        add_row(vert(2, 0, 0, 5, 5, 5), 1, rb);                 // degenerate
        add_row(samp(0, 0, 1, 1, 1), 0, r0);
        foreach (dir_tbl[i]) begin
            send(dir_tbl[i].item);
            if (dir_tbl[i].chk_direct)
                expected_q[expected_q.size() - 1] = dir_tbl[i].res;
        end
        // hit cap: 70 samples inside one big triangle on a single pixel
        send(vert(0, 0, 0, 1000, 2000, 3000));
        send(vert(1, 16*200, 0, 1000, 2000, 3000));
        send(vert(2, 0, 16*200, 65535, 65535, 65535));
        for (int i = 0; i < 70; i++) send(samp(5, 5, $urandom, $urandom, i == 69));
        drain();

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin cfg_write(CfgWidth, 1); cfg_write(CfgHeight, 1); end
                1: begin cfg_write(CfgWidth, 4096); cfg_write(CfgHeight, 4096); end
                2: begin cfg_write(CfgWidth, 0); cfg_write(CfgHeight, 8191); end
                3: begin cfg_write(CfgWidth, 64); cfg_write(CfgHeight, 48); end
                4: begin
                    cfg_write(CfgWidth, $urandom_range(8191));
                    cfg_write(CfgHeight, $urandom_range(8191));
                end
                default: begin cfg_write(CfgWidth, 640); cfg_write(CfgHeight, 480); end
            endcase
            i_cfg_valid <= 0;
            stall_free = (ph == 3);
            for (int t = 0; t < 16; t++) begin
                // small triangle, then a few pixels sampled near it
                cx = $urandom_range(70); cy = $urandom_range(70); sz = $urandom_range(1, 6);
                for (int s = 0; s < 3; s++) begin
                    it = rnd_item();
                    it.func = FuncVertex; it.slot = 2'(s);
                    it.vx = 16'(16*cx + $urandom_range(16*sz));
                    it.vy = 16'(16*cy + $urandom_range(16*sz));
                    send(it);
                end
                for (int p = 0; p < 4; p++) begin
                    nsamp = $urandom_range(1, 4);
                    it = samp(cx + $urandom_range(sz), cy + $urandom_range(sz), 0, 0, 0);
                    for (int q = 0; q < nsamp; q++) begin
                        it.ox = 8'($urandom); it.oy = 8'($urandom);
                        it.last = (q == nsamp - 1);
                        send(it);
                    end
                end
                if ($urandom_range(3) == 0) send(rnd_item());
            end
            drain();
        end

        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
